// ===== src/assert_macros.svh =====
// Assertion macros of the luminance boost filter, included by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define WLB_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define WLB_ASSERT_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define WLB_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define WLB_ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

// ===== src/wlb_pkg.sv =====
// Package with the constants and structure types of the luminance boost filter.
package wlb_pkg;

	localparam int unsigned MAX_WIDTH_DEF = 1024;
	localparam int unsigned WIN_RADIUS    = 2;
	localparam int unsigned LINES         = 2 * WIN_RADIUS;
	localparam int unsigned LANE_W        = $clog2(LINES);
	localparam int unsigned MIN_DIM       = 5;
	localparam int unsigned MAX_HEIGHT    = 4096;

	localparam int unsigned PX_W       = 32;
	localparam int unsigned CH_W       = 8;
	localparam int unsigned ROW_W      = 12;
	localparam int unsigned OCOL_W     = 10;
	localparam int unsigned HGT_W      = 13;
	localparam int unsigned CFG_WID_W  = 11;
	localparam int unsigned GAIN_W     = 9;
	localparam int unsigned CSUM_W     = 12;
	localparam int unsigned SUM_W      = 15;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 13;

	// Normalizer 5*5*255*3*255 and floor(2^32 / normalizer).
	localparam logic [22:0] NORM_K      = 23'd4876875;
	localparam logic [9:0]  RECIP_K     = 10'd880;
	localparam int unsigned RECIP_SHIFT = 32;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	typedef struct packed {
		logic              emit;
		logic              frame_done;
		logic [LANE_W-1:0] lane;
		logic [ROW_W-1:0]  out_row;
		logic [OCOL_W-1:0] out_col;
	} coord_t;

	typedef struct packed {
		logic [SUM_W-1:0]  sum;
		logic [PX_W-1:0]   centre;
		logic [ROW_W-1:0]  out_row;
		logic [OCOL_W-1:0] out_col;
		logic              frame_done;
	} win_t;

	typedef struct packed {
		logic [ROW_W-1:0]  out_row;
		logic [OCOL_W-1:0] out_col;
		logic [CH_W-1:0]   blue;
		logic [CH_W-1:0]   green;
		logic [CH_W-1:0]   red;
		logic [CH_W-1:0]   alpha;
		logic              frame_done;
	} res_t;

endpackage

// ===== src/wlb_ifs.sv =====
// Stream and configuration interfaces of the luminance boost filter.
interface wlb_px_if;
	logic                      valid;
	logic                      ready;
	logic [wlb_pkg::CH_W-1:0] blue_in;
	logic [wlb_pkg::CH_W-1:0] green_in;
	logic [wlb_pkg::CH_W-1:0] red_in;
	logic [wlb_pkg::CH_W-1:0] alpha_in;
	modport source (output valid, blue_in, green_in, red_in, alpha_in, input ready);
	modport sink (input valid, blue_in, green_in, red_in, alpha_in, output ready);
endinterface

interface wlb_res_if;
	logic                        valid;
	logic                        ready;
	logic [wlb_pkg::ROW_W-1:0]  out_row;
	logic [wlb_pkg::OCOL_W-1:0] out_col;
	logic [wlb_pkg::CH_W-1:0]   blue_out;
	logic [wlb_pkg::CH_W-1:0]   green_out;
	logic [wlb_pkg::CH_W-1:0]   red_out;
	logic [wlb_pkg::CH_W-1:0]   alpha_out;
	logic                        frame_done;
	modport source (output valid, out_row, out_col, blue_out, green_out, red_out,
		alpha_out, frame_done, input ready);
	modport sink (input valid, out_row, out_col, blue_out, green_out, red_out,
		alpha_out, frame_done, output ready);
endinterface

interface wlb_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [wlb_pkg::CFG_IDX_W-1:0]  index;
	logic [wlb_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/window_luminance_boost_filter_unit.sv =====
// Top level of the 5x5 local luminance boost filter on a BGRA raster stream.
`include "assert_macros.svh"

// The block takes one BGRA pixel per clock in raster order and, for every pixel at
// least two pixels away from each frame edge, returns the pixel with each color
// scaled by (1 + gain * S / 4876875), floored and saturated to 0..255, where S is
// the sum of r+g+b over the 5x5 window around it; alpha passes unchanged. Border
// pixels produce no result, so a frame of W x H pixels yields (W-4) x (H-4)
// results, each tagged with its row and column and frame_done on the last one.
// Throughput is one pixel per clock: the line store is a single memory whose
// words hold one column of the last four rows, read and written once per pixel
// with read-before-write, and the arithmetic behind it is a fixed pipeline. A
// result passes the stage registers s1 to s5 and then the output register, after
// the pixel that completes its window (two rows and two columns after the centre)
// is transferred in. While the output register holds a result that is not taken,
// the whole pipeline and the input stall. The line store needs no clearing after
// reset; the first four rows of each frame fill it before any result is formed.
// Registers: gain (index 0, signed, 9 bits), image_width (index 1, saturated to
// 5..MAX_WIDTH) and image_height (index 2, saturated to 5..4096); they are to be
// written only while no pixel is in flight. Writes to other indexes are ignored.
module window_luminance_boost_filter_unit #(
	parameter int unsigned MAX_WIDTH = wlb_pkg::MAX_WIDTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	wlb_px_if.sink      in_px,
	wlb_res_if.source   out_res,
	wlb_cfg_if.sink     cfg
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned WX = (CW + 1 > wlb_pkg::CFG_WID_W) ? CW + 1 : wlb_pkg::CFG_WID_W;

	// Configuration registers.
	logic signed [wlb_pkg::GAIN_W-1:0]    gain_q;
	logic [wlb_pkg::CFG_WID_W-1:0]        width_q;
	logic [wlb_pkg::HGT_W-1:0]            height_q;

	// Effective geometry after saturation.
	logic [WX-1:0]                        w_wide;
	logic [CW:0]                          w_eff;
	logic [wlb_pkg::HGT_W-1:0]            h_eff;

	// Pipeline control.
	logic                                 en;
	logic                                 take;
	logic [CW-1:0]                        addr;
	logic [wlb_pkg::LANE_W-1:0]           wr_lane;
	logic [wlb_pkg::PX_W-1:0]             px_in;
	logic                                 v_s1, v_s2, v_s5;
	wlb_pkg::coord_t                      meta_s1;
	logic [wlb_pkg::PX_W-1:0]             px_s1;
	logic [wlb_pkg::LINES*wlb_pkg::PX_W-1:0] rd_data;
	wlb_pkg::win_t                        win_s2;
	wlb_pkg::res_t                        res;

	// Output register.
	logic                                 out_valid_q;
	wlb_pkg::res_t                        res_q;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= '0;
			width_q  <= wlb_pkg::CFG_WID_W'(wlb_pkg::MIN_DIM);
			height_q <= wlb_pkg::HGT_W'(wlb_pkg::MIN_DIM);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				wlb_pkg::REG_GAIN:   gain_q   <= $signed(cfg.data[wlb_pkg::GAIN_W-1:0]);
				wlb_pkg::REG_WIDTH:  width_q  <= cfg.data[wlb_pkg::CFG_WID_W-1:0];
				wlb_pkg::REG_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Saturate the programmed geometry to the supported range.
	always_comb begin
		w_wide = WX'(width_q);
		if (w_wide > WX'(MAX_WIDTH)) begin
			w_eff = (CW+1)'(MAX_WIDTH);
		end else if (width_q < wlb_pkg::CFG_WID_W'(wlb_pkg::MIN_DIM)) begin
			w_eff = (CW+1)'(wlb_pkg::MIN_DIM);
		end else begin
			w_eff = (CW+1)'(width_q);
		end
		if (height_q > wlb_pkg::HGT_W'(wlb_pkg::MAX_HEIGHT)) begin
			h_eff = wlb_pkg::HGT_W'(wlb_pkg::MAX_HEIGHT);
		end else if (height_q < wlb_pkg::HGT_W'(wlb_pkg::MIN_DIM)) begin
			h_eff = wlb_pkg::HGT_W'(wlb_pkg::MIN_DIM);
		end else begin
			h_eff = height_q;
		end
	end

	// The pipeline moves whenever the output register is empty or being emptied.
	assign en          = !out_valid_q || out_res.ready;
	assign take        = in_px.valid && en;
	assign in_px.ready = en;
	assign px_in       = {in_px.alpha_in, in_px.red_in, in_px.green_in, in_px.blue_in};

	wlb_coord #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_coord (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.take    (take),
		.w_eff   (w_eff),
		.h_eff   (h_eff),
		.px_in   (px_in),
		.addr    (addr),
		.wr_lane (wr_lane),
		.v_s1    (v_s1),
		.meta_s1 (meta_s1),
		.px_s1   (px_s1)
	);

	wlb_line_mem #(
		.DEPTH (MAX_WIDTH)
	) u_line_mem (
		.clk     (clk),
		.take    (take),
		.addr    (addr),
		.wr_lane (wr_lane),
		.wr_data (px_in),
		.rd_data (rd_data)
	);

	wlb_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_s1    (v_s1),
		.meta_s1 (meta_s1),
		.px_s1   (px_s1),
		.rd_data (rd_data),
		.v_s2    (v_s2),
		.win_s2  (win_s2)
	);

	wlb_filter u_filter (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.gain   (gain_q),
		.v_s2   (v_s2),
		.win_s2 (win_s2),
		.v_s5   (v_s5),
		.res    (res)
	);

	// The output register separates the result transfer from the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s5) begin
			res_q <= res;
		end
	end

	assign out_res.valid      = out_valid_q;
	assign out_res.out_row    = res_q.out_row;
	assign out_res.out_col    = res_q.out_col;
	assign out_res.blue_out   = res_q.blue;
	assign out_res.green_out  = res_q.green;
	assign out_res.red_out    = res_q.red;
	assign out_res.alpha_out  = res_q.alpha;
	assign out_res.frame_done = res_q.frame_done;

	// No pixel enters while a result waits to be taken.
	`WLB_ASSERT_NEVER(a_no_take_on_stall, clk, arst_n, (in_px.valid && in_px.ready && out_res.valid && !out_res.ready))
	// Results only come from interior rows.
	`WLB_ASSERT_IMPLY(a_row_interior, clk, arst_n, out_res.valid, (out_res.out_row >= wlb_pkg::ROW_W'(wlb_pkg::WIN_RADIUS)))

endmodule

// ===== src/wlb_coord.sv =====
// Raster position counters and the input stage register of the filter.
module wlb_coord #(
	parameter int unsigned MAX_WIDTH = wlb_pkg::MAX_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               take,
	input  logic [$clog2(MAX_WIDTH):0]         w_eff,
	input  logic [wlb_pkg::HGT_W-1:0]          h_eff,
	input  logic [wlb_pkg::PX_W-1:0]           px_in,
	output logic [$clog2(MAX_WIDTH)-1:0]       addr,
	output logic [wlb_pkg::LANE_W-1:0]         wr_lane,
	output logic                               v_s1,
	output wlb_pkg::coord_t                    meta_s1,
	output logic [wlb_pkg::PX_W-1:0]           px_s1
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam logic [CW:0] ONE_W = 1;

	logic [CW:0]                 col_q;
	logic [wlb_pkg::ROW_W-1:0]   row_q;
	logic                        wrap_c;
	logic [CW-1:0]               c0;
	logic [wlb_pkg::HGT_W-1:0]   r_inc;
	logic [wlb_pkg::ROW_W-1:0]   r0;
	logic [CW:0]                 c_inc;
	logic                        wrap_e;
	logic [wlb_pkg::HGT_W-1:0]   r_nxt;
	logic [CW:0]                 col_nxt;
	logic [wlb_pkg::ROW_W-1:0]   row_nxt;
	logic [CW-1:0]               c_m;
	logic [CW+wlb_pkg::OCOL_W-1:0] col_ext;
	wlb_pkg::coord_t             meta;

	always_comb begin
		// A column count at or past the row length closes the row first.
		wrap_c  = (col_q >= w_eff);
		c0      = wrap_c ? '0 : col_q[CW-1:0];
		r_inc   = {1'b0, row_q} + (wrap_c ? wlb_pkg::HGT_W'(1) : wlb_pkg::HGT_W'(0));
		r0      = (r_inc >= h_eff) ? '0 : r_inc[wlb_pkg::ROW_W-1:0];
		c_m     = c0 - CW'(wlb_pkg::WIN_RADIUS);
		col_ext = {{wlb_pkg::OCOL_W{1'b0}}, c_m};

		// The end of a row and of the frame wraps with the geometry of this pixel.
		c_inc   = {1'b0, c0} + ONE_W;
		wrap_e  = (c_inc >= w_eff);
		r_nxt   = {1'b0, r0} + wlb_pkg::HGT_W'(1);
		col_nxt = wrap_e ? '0 : c_inc;
		row_nxt = !wrap_e ? r0 :
			((r_nxt >= h_eff) ? '0 : r_nxt[wlb_pkg::ROW_W-1:0]);

		meta.emit       = (r0 >= wlb_pkg::ROW_W'(2 * wlb_pkg::WIN_RADIUS)) &&
			(c0 >= CW'(2 * wlb_pkg::WIN_RADIUS));
		meta.frame_done = ({1'b0, r0} == h_eff - wlb_pkg::HGT_W'(1)) &&
			({1'b0, c0} == w_eff - ONE_W);
		meta.lane       = r0[wlb_pkg::LANE_W-1:0];
		meta.out_row    = r0 - wlb_pkg::ROW_W'(wlb_pkg::WIN_RADIUS);
		meta.out_col    = col_ext[wlb_pkg::OCOL_W-1:0];

		addr    = c0;
		wr_lane = meta.lane;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			if (take) begin
				col_q <= col_nxt;
				row_q <= row_nxt;
			end
			if (en) begin
				v_s1 <= take;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			meta_s1 <= meta;
			px_s1   <= px_in;
		end
	end

endmodule

// ===== src/wlb_line_mem.sv =====
// Line store: one word per column holding that column's pixels of the last rows.
module wlb_line_mem #(
	parameter int unsigned DEPTH = wlb_pkg::MAX_WIDTH_DEF
) (
	input  logic                                      clk,
	input  logic                                      take,
	input  logic [$clog2(DEPTH)-1:0]                  addr,
	input  logic [wlb_pkg::LANE_W-1:0]                wr_lane,
	input  logic [wlb_pkg::PX_W-1:0]                  wr_data,
	output logic [wlb_pkg::LINES*wlb_pkg::PX_W-1:0]  rd_data
);

	logic [wlb_pkg::LINES*wlb_pkg::PX_W-1:0] mem [DEPTH];

	// Read-first: the lane being overwritten holds the oldest row, which is still summed.
	always_ff @(posedge clk) begin
		if (take) begin
			rd_data <= mem[addr];
			for (int i = 0; i < int'(wlb_pkg::LINES); i++) begin
				if (wr_lane == wlb_pkg::LANE_W'(i)) begin
					mem[addr][i*wlb_pkg::PX_W +: wlb_pkg::PX_W] <= wr_data;
				end
			end
		end
	end

endmodule

// ===== src/wlb_window.sv =====
// Column sums, window sum and centre pixel delay of the filter.
module wlb_window (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      en,
	input  logic                                      v_s1,
	input  wlb_pkg::coord_t                           meta_s1,
	input  logic [wlb_pkg::PX_W-1:0]                  px_s1,
	input  logic [wlb_pkg::LINES*wlb_pkg::PX_W-1:0]  rd_data,
	output logic                                      v_s2,
	output wlb_pkg::win_t                             win_s2
);

	function automatic logic [9:0] rgb3(input logic [wlb_pkg::PX_W-1:0] p);
		rgb3 = 10'(p[7:0]) + 10'(p[15:8]) + 10'(p[23:16]);
	endfunction

	logic [wlb_pkg::CSUM_W-1:0] colsum_q [wlb_pkg::LINES];
	logic [wlb_pkg::PX_W-1:0]   dly_q [2];
	logic [wlb_pkg::CSUM_W-1:0] csum_new;
	logic [wlb_pkg::SUM_W-1:0]  sum_new;
	logic [wlb_pkg::LANE_W-1:0] lane_c;
	logic [wlb_pkg::PX_W-1:0]   lane_px;

	always_comb begin
		csum_new = wlb_pkg::CSUM_W'(rgb3(px_s1));
		for (int i = 0; i < int'(wlb_pkg::LINES); i++) begin
			csum_new = csum_new +
				wlb_pkg::CSUM_W'(rgb3(rd_data[i*wlb_pkg::PX_W +: wlb_pkg::PX_W]));
		end
		sum_new = wlb_pkg::SUM_W'(csum_new);
		for (int i = 0; i < int'(wlb_pkg::LINES); i++) begin
			sum_new = sum_new + wlb_pkg::SUM_W'(colsum_q[i]);
		end
		// The lane of the row two above the current one holds the future centre.
		lane_c  = meta_s1.lane ^ wlb_pkg::LANE_W'(wlb_pkg::WIN_RADIUS);
		lane_px = '0;
		for (int i = 0; i < int'(wlb_pkg::LINES); i++) begin
			if (lane_c == wlb_pkg::LANE_W'(i)) begin
				lane_px = rd_data[i*wlb_pkg::PX_W +: wlb_pkg::PX_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(wlb_pkg::LINES); i++) begin
				colsum_q[i] <= '0;
			end
			dly_q[0] <= '0;
			dly_q[1] <= '0;
			v_s2     <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1 && meta_s1.emit;
			if (v_s1) begin
				for (int i = 0; i < int'(wlb_pkg::LINES) - 1; i++) begin
					colsum_q[i] <= colsum_q[i+1];
				end
				colsum_q[wlb_pkg::LINES-1] <= csum_new;
				dly_q[1] <= dly_q[0];
				dly_q[0] <= lane_px;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			win_s2.sum        <= sum_new;
			win_s2.centre     <= dly_q[1];
			win_s2.out_row    <= meta_s1.out_row;
			win_s2.out_col    <= meta_s1.out_col;
			win_s2.frame_done <= meta_s1.frame_done;
		end
	end

endmodule

// ===== src/wlb_filter.sv =====
// Gain arithmetic and exact floor division by the normalizer for the three colors.
module wlb_filter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic signed [wlb_pkg::GAIN_W-1:0]  gain,
	input  logic                               v_s2,
	input  wlb_pkg::win_t                      win_s2,
	output logic                               v_s5,
	output wlb_pkg::res_t                      res
);

	localparam int unsigned M_W = 24;
	localparam int unsigned N_W = 32;
	localparam int unsigned P_W = N_W + 10;
	localparam int unsigned Q_W = 9;

	typedef struct packed {
		logic [wlb_pkg::ROW_W-1:0]  out_row;
		logic [wlb_pkg::OCOL_W-1:0] out_col;
		logic [wlb_pkg::CH_W-1:0]   alpha;
		logic                       frame_done;
	} meta_t;

	logic signed [24:0]        gs;
	logic signed [25:0]        m_full;
	logic [M_W-1:0]            m_s3;
	logic [wlb_pkg::CH_W-1:0]  ch_s3 [3];
	meta_t                     meta_s3, meta_s4, meta_s5;
	logic [N_W-1:0]            n_s4 [3];
	logic [N_W-1:0]            n_s5 [3];
	logic [Q_W-1:0]            q_s5 [3];
	logic                      v_s3, v_s4;
	logic [N_W-1:0]            n_mul [3];
	logic [P_W-1:0]            p_mul [3];
	logic [N_W-1:0]            k_mul [3];
	logic [N_W-1:0]            rem [3];
	logic [Q_W:0]              q_fix [3];
	logic [wlb_pkg::CH_W-1:0]  ch_out [3];

	always_comb begin
		// The multiplier stays at or below 2K; only the most negative gain can push it below
		// zero, and then every channel saturates to zero.
		gs     = gain * $signed({1'b0, win_s2.sum});
		m_full = $signed({3'b0, wlb_pkg::NORM_K}) + 26'(gs);
		for (int i = 0; i < 3; i++) begin
			n_mul[i] = N_W'(ch_s3[i]) * N_W'(m_s3);
			p_mul[i] = P_W'(n_s4[i]) * P_W'(wlb_pkg::RECIP_K);
			// The reciprocal estimate is exact or one low.
			k_mul[i] = N_W'(q_s5[i]) * N_W'(wlb_pkg::NORM_K);
			rem[i]   = n_s5[i] - k_mul[i];
			q_fix[i] = (rem[i] >= N_W'(wlb_pkg::NORM_K)) ? ({1'b0, q_s5[i]} + 1'b1) :
				{1'b0, q_s5[i]};
			ch_out[i] = (q_fix[i] > (Q_W+1)'(255)) ? '1 : q_fix[i][wlb_pkg::CH_W-1:0];
		end
		res.out_row    = meta_s5.out_row;
		res.out_col    = meta_s5.out_col;
		res.blue       = ch_out[0];
		res.green      = ch_out[1];
		res.red        = ch_out[2];
		res.alpha      = meta_s5.alpha;
		res.frame_done = meta_s5.frame_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s2) begin
				m_s3               <= m_full[25] ? '0 : m_full[M_W-1:0];
				ch_s3[0]           <= win_s2.centre[7:0];
				ch_s3[1]           <= win_s2.centre[15:8];
				ch_s3[2]           <= win_s2.centre[23:16];
				meta_s3.out_row    <= win_s2.out_row;
				meta_s3.out_col    <= win_s2.out_col;
				meta_s3.alpha      <= win_s2.centre[31:24];
				meta_s3.frame_done <= win_s2.frame_done;
			end
			if (v_s3) begin
				for (int i = 0; i < 3; i++) begin
					n_s4[i] <= n_mul[i];
				end
				meta_s4 <= meta_s3;
			end
			if (v_s4) begin
				for (int i = 0; i < 3; i++) begin
					n_s5[i] <= n_s4[i];
					q_s5[i] <= p_mul[i][wlb_pkg::RECIP_SHIFT + Q_W - 1:wlb_pkg::RECIP_SHIFT];
				end
				meta_s5 <= meta_s4;
			end
		end
	end

endmodule
